// ----- src/vfa_pkg.sv -----
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, codes and constants of the 2D fixed-point vector unit.
// ----------------------------------------------------------------------------
package vfa_pkg;

  // defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;

  // CORDIC datapath widths: x/y need headroom for the gain, z one guard bit
  localparam int XW = 35;
  localparam int ZW = 33;

  // 1/K in Q30 and binary angles (2^31 = pi)
  localparam logic [30:0]          INV_GAIN_Q30 = 31'd652032874;
  localparam logic signed [ZW-1:0] HALF_PI      = 33'sh040000000;
  localparam logic signed [ZW-1:0] PI_BA        = 33'sh080000000;

  typedef enum logic [2:0] {
    ACT_ADD        = 3'd0,
    ACT_SUB        = 3'd1,
    ACT_SCALE      = 3'd2,
    ACT_DIVIDE     = 3'd3,
    ACT_DOT        = 3'd4,
    ACT_CROSS      = 3'd5,
    ACT_TO_POLAR   = 3'd6,
    ACT_FROM_POLAR = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
  } xy_res_t;

  typedef struct packed {
    xy_res_t            xy;
    logic signed [63:0] prod;
    logic               prod_sat;
  } mul_res_t;

  typedef struct packed {
    xy_res_t            xy;
    logic [31:0]        radius;
    logic signed [31:0] angle;
  } pol_res_t;

  typedef struct packed {
    logic signed [31:0] q;
    logic               sat;
  } div_res_t;

  // truncated arctangent table, atan(2^-i) as a binary angle
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      24: a = 32'h00000028;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000002;
      29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ----- src/vfa_delay.sv -----
// ----------------------------------------------------------------------------
// vfa_delay
// Enabled delay line that aligns a unit's result with the longest unit.
// ----------------------------------------------------------------------------
module vfa_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [WIDTH-1:0] line [0:DEPTH-1];

      // advance the whole line together with the pipeline
      always_ff @(posedge clk) begin
        if (en) begin
          line[0] <= d;
          for (int k = 1; k < DEPTH; k++) begin
            line[k] <= line[k-1];
          end
        end
      end

      assign q = line[DEPTH-1];
    end
  endgenerate

endmodule

// ----- src/vfa_mul.sv -----
// ----------------------------------------------------------------------------
// vfa_mul
// Three-stage lane for add, sub, scale, dot and cross: multiply, sum, clip.
// ----------------------------------------------------------------------------
module vfa_mul import vfa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  action_t            action,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] scalar,
  output mul_res_t           res
);

  localparam logic signed [65:0] SAT_HI  = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO  = -SAT_HI - 66'sd1;
  localparam logic signed [64:0] HALF    = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] PROD_HI = (65'sd1 <<< 63) - 65'sd1;

  logic signed [31:0] op0, op1;
  action_t            act1, act2;
  logic signed [63:0] m0, m1;
  logic signed [32:0] s0, s1;
  logic signed [64:0] vx, vy, ps;
  logic signed [64:0] vx2, vy2, ps2;
  logic signed [65:0] ex, ey;
  mul_res_t           res_next;

  // pick the second multiplier operand per action
  always_comb begin
    case (action)
      ACT_DOT: begin
        op0 = bx;
        op1 = by;
      end
      ACT_CROSS: begin
        op0 = by;
        op1 = bx;
      end
      default: begin
        op0 = scalar;
        op1 = scalar;
      end
    endcase
  end

  // stage 1: products and plain sums
  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= action;
      m0   <= ax * op0;
      m1   <= ay * op1;
      if (action == ACT_SUB) begin
        s0 <= 33'(ax) - 33'(bx);
        s1 <= 33'(ay) - 33'(by);
      end else begin
        s0 <= 33'(ax) + 33'(bx);
        s1 <= 33'(ay) + 33'(by);
      end
    end
  end

  // stage 2: rounding shift for scale, product sum for dot and cross
  always_comb begin
    case (act1)
      ACT_ADD, ACT_SUB: begin
        vx = 65'(s0);
        vy = 65'(s1);
      end
      default: begin
        vx = (65'(m0) + HALF) >>> FRAC_BITS;
        vy = (65'(m1) + HALF) >>> FRAC_BITS;
      end
    endcase
    if (act1 == ACT_CROSS) begin
      ps = 65'(m0) - 65'(m1);
    end else begin
      ps = 65'(m0) + 65'(m1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act1;
      vx2  <= vx;
      vy2  <= vy;
      ps2  <= ps;
    end
  end

  // stage 3: clip to the coordinate range and to 64 bits
  always_comb begin
    ex = 66'(vx2);
    ey = 66'(vy2);
    res_next.xy.sat = 1'b0;
    if (ex > SAT_HI) begin
      res_next.xy.x   = SAT_HI[31:0];
      res_next.xy.sat = 1'b1;
    end else if (ex < SAT_LO) begin
      res_next.xy.x   = SAT_LO[31:0];
      res_next.xy.sat = 1'b1;
    end else begin
      res_next.xy.x = ex[31:0];
    end
    if (ey > SAT_HI) begin
      res_next.xy.y   = SAT_HI[31:0];
      res_next.xy.sat = 1'b1;
    end else if (ey < SAT_LO) begin
      res_next.xy.y   = SAT_LO[31:0];
      res_next.xy.sat = 1'b1;
    end else begin
      res_next.xy.y = ey[31:0];
    end
    if (ps2 > PROD_HI) begin
      res_next.prod     = PROD_HI[63:0];
      res_next.prod_sat = 1'b1;
    end else begin
      res_next.prod     = ps2[63:0];
      res_next.prod_sat = 1'b0;
    end
    // dot and cross report no coordinate saturation, whatever the lane computed
    if (act2 == ACT_DOT || act2 == ACT_CROSS) begin
      res_next.xy.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ----- src/vfa_div.sv -----
// ----------------------------------------------------------------------------
// vfa_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero and clipped to the coordinate range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module vfa_div import vfa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output div_res_t           res
);

  localparam int DQ = 32 + FRAC_BITS;
  localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

  logic [DQ-1:0] dvd  [0:DQ];
  logic [31:0]   rem  [0:DQ];
  logic [31:0]   dmag [0:DQ];
  logic          neg  [0:DQ];

  logic [31:0]        nmag, dm;
  logic signed [DQ:0] qs;
  logic signed [65:0] qe;
  div_res_t           res_next;

  // take magnitudes; -2^31 maps to 2^31 in the unsigned word
  always_comb begin
    nmag = num[31] ? 32'(-num) : 32'(num);
    dm   = den[31] ? 32'(-den) : 32'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd[0]  <= {nmag, FRAC_BITS'(0)};
      rem[0]  <= '0;
      dmag[0] <= dm;
      neg[0]  <= num[31] ^ den[31];
    end
  end

  // one trial subtraction per stage; quotient bits shift in behind the dividend
  generate
    for (genvar k = 0; k < DQ; k++) begin : g_step
      logic [32:0] trial, diff;
      logic        take;

      always_comb begin
        trial = {rem[k], dvd[k][DQ-1]};
        diff  = trial - {1'b0, dmag[k]};
        take  = !diff[32];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]  <= take ? diff[31:0] : trial[31:0];
          dvd[k+1]  <= {dvd[k][DQ-2:0], take};
          dmag[k+1] <= dmag[k];
          neg[k+1]  <= neg[k];
        end
      end
    end
  endgenerate

  // apply the sign and clip
  always_comb begin
    qs = neg[DQ] ? -$signed({1'b0, dvd[DQ]}) : $signed({1'b0, dvd[DQ]});
    qe = 66'(qs);
    if (qe > SAT_HI) begin
      res_next.q   = SAT_HI[31:0];
      res_next.sat = 1'b1;
    end else if (qe < SAT_LO) begin
      res_next.q   = SAT_LO[31:0];
      res_next.sat = 1'b1;
    end else begin
      res_next.q   = qe[31:0];
      res_next.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ----- src/vfa_cordic.sv -----
// ----------------------------------------------------------------------------
// vfa_cordic
// Pipelined CORDIC, one micro-rotation per stage. Vectoring mode gives
// radius and angle; rotation mode turns (r, angle) into x and y.
// ----------------------------------------------------------------------------
module vfa_cordic import vfa_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic               vec,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic [30:0]        radius,
  input  logic signed [31:0] angle,
  output pol_res_t           res
);

  localparam int N = CORDIC_STEPS;
  localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
  localparam logic signed [65:0] RND    = 66'sd1 <<< 29;
  localparam logic signed [65:0] RAD_HI = 66'sh0FFFFFFFF;

  // prepare stage
  logic signed [XW-1:0] x_pre, y_pre;
  logic signed [ZW-1:0] z_pre, za;
  logic                 neg_pre;
  logic                 vec1, zero1, neg1;
  logic signed [XW-1:0] x1, y1;
  logic signed [ZW-1:0] z1;
  logic [61:0]          gp1;

  // rotation pipe, index 0 is the start value
  logic signed [XW-1:0] xs [0:N];
  logic signed [XW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic                 vs [0:N];
  logic                 zf [0:N];
  logic                 nf [0:N];

  // gain stage
  logic signed [65:0]   pr;
  logic signed [XW-1:0] xq, yq;
  logic signed [ZW-1:0] zq;
  logic                 vq, zfq, nfq;

  logic signed [65:0]   rr, ex, ey;
  logic [61:0]          gr;
  pol_res_t             res_next;

  // turn left half-plane vectors by 90 degrees; fold far angles by pi
  always_comb begin
    x_pre = XW'(ax);
    y_pre = XW'(ay);
    z_pre = '0;
    if (ax < 0) begin
      if (ay >= 0) begin
        x_pre = XW'(ay);
        y_pre = -XW'(ax);
        z_pre = HALF_PI;
      end else begin
        x_pre = -XW'(ay);
        y_pre = XW'(ax);
        z_pre = -HALF_PI;
      end
    end
    za      = ZW'(angle);
    neg_pre = 1'b0;
    if (za > HALF_PI) begin
      za      = za - PI_BA;
      neg_pre = 1'b1;
    end else if (za < -HALF_PI) begin
      za      = za + PI_BA;
      neg_pre = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1  <= vec;
      zero1 <= (ax == 32'sd0) && (ay == 32'sd0);
      neg1  <= vec ? 1'b0 : neg_pre;
      x1    <= x_pre;
      y1    <= y_pre;
      z1    <= vec ? z_pre : za;
      gp1   <= radius * INV_GAIN_Q30;
    end
  end

  // start value: rounded r / K for rotation
  always_comb begin
    gr = (gp1 + 62'(1 << 29)) >> 30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= vec1 ? x1 : XW'(gr);
      ys[0] <= vec1 ? y1 : '0;
      zs[0] <= z1;
      vs[0] <= vec1;
      zf[0] <= zero1;
      nf[0] <= neg1;
    end
  end

  // micro-rotations
  generate
    for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(i));
      logic signed [XW-1:0] dx, dy;
      logic                 plus;

      always_comb begin
        dx   = ys[i] >>> i;
        dy   = xs[i] >>> i;
        plus = vs[i] ? !ys[i][XW-1] : zs[i][ZW-1];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (plus) begin
            xs[i+1] <= xs[i] + dx;
            ys[i+1] <= ys[i] - dy;
            zs[i+1] <= zs[i] + ATAN;
          end else begin
            xs[i+1] <= xs[i] - dx;
            ys[i+1] <= ys[i] + dy;
            zs[i+1] <= zs[i] - ATAN;
          end
          vs[i+1] <= vs[i];
          zf[i+1] <= zf[i];
          nf[i+1] <= nf[i];
        end
      end
    end
  endgenerate

  // gain correction product
  always_ff @(posedge clk) begin
    if (en) begin
      pr  <= xs[N] * $signed({1'b0, INV_GAIN_Q30});
      xq  <= xs[N];
      yq  <= ys[N];
      zq  <= zs[N];
      vq  <= vs[N];
      zfq <= zf[N];
      nfq <= nf[N];
    end
  end

  // round radius, undo the fold, clip
  always_comb begin
    rr = (pr + RND) >>> 30;
    ex = nfq ? -66'(xq) : 66'(xq);
    ey = nfq ? -66'(yq) : 66'(yq);
    res_next.xy.sat = 1'b0;
    if (ex > SAT_HI) begin
      res_next.xy.x   = SAT_HI[31:0];
      res_next.xy.sat = 1'b1;
    end else if (ex < SAT_LO) begin
      res_next.xy.x   = SAT_LO[31:0];
      res_next.xy.sat = 1'b1;
    end else begin
      res_next.xy.x = ex[31:0];
    end
    if (ey > SAT_HI) begin
      res_next.xy.y   = SAT_HI[31:0];
      res_next.xy.sat = 1'b1;
    end else if (ey < SAT_LO) begin
      res_next.xy.y   = SAT_LO[31:0];
      res_next.xy.sat = 1'b1;
    end else begin
      res_next.xy.y = ey[31:0];
    end
    if (!vq || zfq) begin
      res_next.radius = '0;
      res_next.angle  = '0;
    end else begin
      res_next.radius = (rr > RAD_HI) ? 32'hFFFFFFFF : rr[31:0];
      res_next.angle  = zq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ----- src/vector2d_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// vector2d_fixed_point_alu
// 2D vector unit in signed Q16.16: add, sub, scale, divide, dot, cross,
// Cartesian to polar and polar to Cartesian.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ channel: s_tuser carries the action code,
//   s_tdata the operands. Each accepted word yields exactly one result word
//   on the m_ channel, in order.
//   All units run side by side in one pipeline; shorter units are padded so
//   every action has the same latency, with DEPTH set by the longest unit;
//   at the defaults that is the divider (34 + FRAC_BITS stages, a quotient
//   bit in each trial stage).
//   Throughput is one word per cycle while the receiver does not stall, with no gaps between actions.
//   Reset clears all valid bits; the pipeline comes up empty and s_tready is
//   high in the first cycle after reset.
//   When the receiver stalls with a result waiting, the whole pipeline holds:
//   s_tready drops, and nothing in flight is lost or repeated. While the
//   output register is empty or being taken, a new word enters every cycle.
// ----------------------------------------------------------------------------
module vector2d_fixed_point_alu import vfa_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ax[31:0], ay[63:32], bx[95:64], by[127:96], scalar[159:128],
  // radius_in[190:160], angle_in[222:191], zero pad
  input  logic [223:0] s_tdata,
  // action[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x[31:0], out_y[63:32], out_product[127:64], out_radius[159:128],
  // out_angle[191:160], status[193:192], zero pad
  output logic [199:0] m_tdata
);

  localparam int MUL_LAT  = 3;
  localparam int DIV_LAT  = 34 + FRAC_BITS;
  localparam int CORD_LAT = CORDIC_STEPS + 4;
  localparam int DEPTH_A  = (DIV_LAT > CORD_LAT) ? DIV_LAT : CORD_LAT;
  localparam int DEPTH    = (DEPTH_A > MUL_LAT) ? DEPTH_A : MUL_LAT;

  logic               adv;
  action_t            action;
  logic signed [31:0] ax, ay, bx, by, scalar, angle_in;
  logic [30:0]        radius_in;

  logic [DEPTH-1:0]   vpipe;
  logic [3:0]         ctl_d;
  action_t            act_d;
  logic               dz_d;

  mul_res_t mul_r, mul_d;
  div_res_t divx_r, divy_r, divx_d, divy_d;
  pol_res_t pol_r, pol_d;

  logic               ovld;
  logic signed [31:0] ox, oy, oang;
  logic signed [63:0] oprod;
  logic [31:0]        orad;
  status_t            ost;

  logic signed [31:0] ox_next, oy_next, oang_next;
  logic signed [63:0] oprod_next;
  logic [31:0]        orad_next;
  status_t            ost_next;

  // unpack the input word
  assign action    = action_t'(s_tuser);
  assign ax        = s_tdata[31:0];
  assign ay        = s_tdata[63:32];
  assign bx        = s_tdata[95:64];
  assign by        = s_tdata[127:96];
  assign scalar    = s_tdata[159:128];
  assign radius_in = s_tdata[190:160];
  assign angle_in  = s_tdata[222:191];

  // the pipeline moves whenever the output register can take a word
  assign adv      = !ovld || m_tready;
  assign s_tready = adv;

  // valid bits travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[DEPTH-2:0], s_tvalid};
    end
  end

  vfa_delay #(.WIDTH(4), .DEPTH(DEPTH)) u_ctl (
    .clk (clk),
    .en  (adv),
    .d   ({action, scalar == 32'sd0}),
    .q   (ctl_d)
  );
  assign act_d = action_t'(ctl_d[3:1]);
  assign dz_d  = ctl_d[0];

  vfa_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .en     (adv),
    .action (action),
    .ax     (ax),
    .ay     (ay),
    .bx     (bx),
    .by     (by),
    .scalar (scalar),
    .res    (mul_r)
  );

  vfa_delay #(.WIDTH($bits(mul_res_t)), .DEPTH(DEPTH - MUL_LAT)) u_mul_dly (
    .clk (clk),
    .en  (adv),
    .d   (mul_r),
    .q   (mul_d)
  );

  vfa_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_divx (
    .clk (clk),
    .en  (adv),
    .num (ax),
    .den (scalar),
    .res (divx_r)
  );

  vfa_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_divy (
    .clk (clk),
    .en  (adv),
    .num (ay),
    .den (scalar),
    .res (divy_r)
  );

  vfa_delay #(.WIDTH(2 * $bits(div_res_t)), .DEPTH(DEPTH - DIV_LAT)) u_div_dly (
    .clk (clk),
    .en  (adv),
    .d   ({divx_r, divy_r}),
    .q   ({divx_d, divy_d})
  );

  vfa_cordic #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .en     (adv),
    .vec    (action == ACT_TO_POLAR),
    .ax     (ax),
    .ay     (ay),
    .radius (radius_in),
    .angle  (angle_in),
    .res    (pol_r)
  );

  vfa_delay #(.WIDTH($bits(pol_res_t)), .DEPTH(DEPTH - CORD_LAT)) u_pol_dly (
    .clk (clk),
    .en  (adv),
    .d   (pol_r),
    .q   (pol_d)
  );

  // pick the fields of the action; unused fields stay zero
  always_comb begin
    ox_next    = '0;
    oy_next    = '0;
    oprod_next = '0;
    orad_next  = '0;
    oang_next  = '0;
    ost_next   = ST_OK;
    case (act_d)
      ACT_ADD, ACT_SUB, ACT_SCALE: begin
        ox_next  = mul_d.xy.x;
        oy_next  = mul_d.xy.y;
        ost_next = mul_d.xy.sat ? ST_SAT : ST_OK;
      end
      ACT_DIVIDE: begin
        if (dz_d) begin
          ost_next = ST_DIVZ;
        end else begin
          ox_next  = divx_d.q;
          oy_next  = divy_d.q;
          ost_next = (divx_d.sat || divy_d.sat) ? ST_SAT : ST_OK;
        end
      end
      ACT_DOT, ACT_CROSS: begin
        oprod_next = mul_d.prod;
        ost_next   = mul_d.prod_sat ? ST_SAT : ST_OK;
      end
      ACT_TO_POLAR: begin
        orad_next = pol_d.radius;
        oang_next = pol_d.angle;
      end
      ACT_FROM_POLAR: begin
        ox_next  = pol_d.xy.x;
        oy_next  = pol_d.xy.y;
        ost_next = pol_d.xy.sat ? ST_SAT : ST_OK;
      end
      default: begin
        ost_next = ST_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (adv) begin
      ovld <= vpipe[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox    <= ox_next;
      oy    <= oy_next;
      oprod <= oprod_next;
      orad  <= orad_next;
      oang  <= oang_next;
      ost   <= ost_next;
    end
  end

  assign m_tvalid = ovld;
  assign m_tdata  = {6'b0, ost, oang, orad, oprod, oy, ox};

  // the pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // a division by zero reports nothing but the error
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[193:192] == ST_DIVZ |->
      m_tdata[63:0] == 64'd0 && m_tdata[191:64] == 128'd0)
    else $error("divide-by-zero word carries nonzero fields");

  // the status field never holds the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[193:192] != 2'd3)
    else $error("status field holds an unused code");

  // a word leaves the last stage only when the output side can take it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(vpipe))
    else $error("pipeline moved while the output word was stalled");

endmodule

// ----- sim/tb_vector2d_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// tb_vector2d_fixed_point_alu
// Self-checking bench for the 2D fixed-point vector unit. A behavioral copy of
// each operation predicts every result word, and a scoreboard compares the
// words leaving the unit in order, field by field.
// ----------------------------------------------------------------------------
module tb_vector2d_fixed_point_alu;
  import vfa_pkg::*;

  // expected fields of one result word
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [63:0] prod;
    logic [31:0]        radius;
    logic signed [31:0] angle;
    status_t            status;
  } vec_result_t;

  // compute the result word for one input word
  function automatic vec_result_t vec_predict(action_t act, logic signed [31:0] ax,
      logic signed [31:0] ay, logic signed [31:0] bx, logic signed [31:0] by,
      logic signed [31:0] sc, logic [30:0] rin, logic signed [31:0] ang);
    vec_result_t r;
    logic signed [63:0] vx, vy, p, q, x, y, z, dx, dy, t;
    logic sat;
    logic neg;
    r.x = 0; r.y = 0; r.prod = 0; r.radius = 0; r.angle = 0; r.status = ST_OK;
    sat = 0; vx = 0; vy = 0; neg = 0;
    case (act)
      ACT_ADD: begin
        vx = 64'(ax) + 64'(bx); vy = 64'(ay) + 64'(by);
      end
      ACT_SUB: begin
        vx = 64'(ax) - 64'(bx); vy = 64'(ay) - 64'(by);
      end
      ACT_SCALE: begin
        vx = (64'(ax) * 64'(sc) + 64'sd32768) >>> 16;
        vy = (64'(ay) * 64'(sc) + 64'sd32768) >>> 16;
      end
      ACT_DIVIDE: begin
        if (sc != 0) begin
          vx = (64'(ax) <<< 16) / 64'(sc);
          vy = (64'(ay) <<< 16) / 64'(sc);
        end
      end
      ACT_DOT, ACT_CROSS: begin
        p = (act == ACT_DOT) ? 64'(ax) * 64'(bx) : 64'(ax) * 64'(by);
        q = (act == ACT_DOT) ? 64'(ay) * 64'(by) : -(64'(ay) * 64'(bx));
        // only sum of two products near +2^62 each can overflow
        if (q > 0 && p > 64'sh7FFFFFFFFFFFFFFF - q) begin
          r.prod = 64'sh7FFFFFFFFFFFFFFF; sat = 1;
        end else begin
          r.prod = p + q;
        end
      end
      ACT_TO_POLAR: begin
        if (ax != 0 || ay != 0) begin
          x = ax; y = ay; z = 0;
          // fold left half-plane into the right one
          if (x < 0) begin
            t = x;
            if (y >= 0) begin
              x = y; y = -t; z = 64'sd1073741824;
            end else begin
              x = -y; y = t; z = -64'sd1073741824;
            end
          end
          for (int i = 0; i < 24; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin
              x = x + dx; y = y - dy; z = z + 64'(atan_entry(i));
            end else begin
              x = x - dx; y = y + dy; z = z - 64'(atan_entry(i));
            end
          end
          t = (x * 64'sd652032874 + 64'sd536870912) >>> 30;
          r.radius = (t > 64'sd4294967295) ? 32'hFFFFFFFF : t[31:0];
          r.angle = z[31:0];
        end
      end
      default: begin
        z = ang; y = 0;
        if (z > 64'sd1073741824) begin
          z = z - 64'sd2147483648; neg = 1;
        end else if (z < -64'sd1073741824) begin
          z = z + 64'sd2147483648; neg = 1;
        end
        x = (64'(rin) * 64'sd652032874 + 64'sd536870912) >>> 30;
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i; dy = x >>> i;
          if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - 64'(atan_entry(i));
          end else begin
            x = x + dx; y = y - dy; z = z + 64'(atan_entry(i));
          end
        end
        vx = neg ? -x : x; vy = neg ? -y : y;
      end
    endcase
    // clip vector results to the coordinate range
    if (act inside {ACT_ADD, ACT_SUB, ACT_SCALE, ACT_DIVIDE, ACT_FROM_POLAR}) begin
      if (vx > 64'sd2147483647) begin vx = 64'sd2147483647; sat = 1; end
      if (vx < -64'sd2147483648) begin vx = -64'sd2147483648; sat = 1; end
      if (vy > 64'sd2147483647) begin vy = 64'sd2147483647; sat = 1; end
      if (vy < -64'sd2147483648) begin vy = -64'sd2147483648; sat = 1; end
      r.x = vx[31:0]; r.y = vy[31:0];
    end
    if (act == ACT_DIVIDE && sc == 0) r.status = ST_DIVZ;
    else if (sat) r.status = ST_SAT;
    return r;
  endfunction

  // in-order result tracker
  class vec_scoreboard;
    vec_result_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note_input(logic [2:0] act, logic [223:0] d);
      pending.push_back(vec_predict(action_t'(act), d[31:0], d[63:32], d[95:64],
          d[127:96], d[159:128], d[190:160], d[222:191]));
    endfunction

    function void check_result(logic [199:0] d);
      vec_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[31:0] !== e.x) begin
        $display("%0t: out_x expected %h actual %h", $time, e.x, d[31:0]); errors++;
      end
      if (d[63:32] !== e.y) begin
        $display("%0t: out_y expected %h actual %h", $time, e.y, d[63:32]); errors++;
      end
      if (d[127:64] !== e.prod) begin
        $display("%0t: out_product expected %h actual %h", $time, e.prod, d[127:64]);
        errors++;
      end
      if (d[159:128] !== e.radius) begin
        $display("%0t: out_radius expected %h actual %h", $time, e.radius, d[159:128]);
        errors++;
      end
      if (d[191:160] !== e.angle) begin
        $display("%0t: out_angle expected %h actual %h", $time, e.angle, d[191:160]);
        errors++;
      end
      if (d[193:192] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, d[193:192]);
        errors++;
      end
      if (d[199:194] !== 6'd0) begin
        $display("%0t: pad expected 0 actual %h", $time, d[199:194]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic [2:0]   s_tuser = ACT_ADD;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [199:0] m_tdata;

  vec_scoreboard sb = new();
  int cycles = 0;
  int stall_mode = 0;
  int sent = 0;

  vector2d_fixed_point_alu dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // count cycles and give up at a generous limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // note accepted words, check results, drive receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (cycles[3:0] < 4'd10);
      endcase
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'h00010000;
      4: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      5: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom();
    endcase
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(action_t act, logic [31:0] ax, logic [31:0] ay,
      logic [31:0] bx, logic [31:0] by, logic [31:0] sc, logic [30:0] rin,
      logic [31:0] ang);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, ang, rin, sc, by, bx, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    action_t act;
    act = action_t'($urandom_range(0, 7));
    send_word(act, pick_word(), pick_word(), pick_word(), pick_word(),
        ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word(), 31'(pick_word() >> 1),
        pick_word());
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: every action, extremes and the special cases
    for (int a = 0; a < 8; a++)
      send_word(action_t'(a), 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
          32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(ACT_DIVIDE, 32'h00030000, 32'hFFFD0000, 0, 0, 32'h0, 0, 0);
    send_word(ACT_DIVIDE, 32'h7FFFFFFF, 32'h80000000, 0, 0, 32'h00000001, 0, 0);
    send_word(ACT_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    send_word(ACT_CROSS, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0);
    send_word(ACT_TO_POLAR, 0, 0, 0, 0, 0, 0, 0);
    send_word(ACT_TO_POLAR, 32'hFFFF0000, 0, 0, 0, 0, 0, 0);
    send_word(ACT_TO_POLAR, 32'hFFFF0000, 32'h00010000, 0, 0, 0, 0, 0);
    send_word(ACT_TO_POLAR, 32'hFFFF0000, 32'hFFFF0000, 0, 0, 0, 0, 0);
    send_word(ACT_TO_POLAR, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
    send_word(ACT_FROM_POLAR, 0, 0, 0, 0, 0, 31'h00010000, 32'h80000000);
    send_word(ACT_FROM_POLAR, 0, 0, 0, 0, 0, 31'h00010000, 32'h40000001);
    send_word(ACT_FROM_POLAR, 0, 0, 0, 0, 0, 31'h00010000, 32'hBFFFFFFF);
    send_word(ACT_SCALE, 32'h00018000, 32'hFFFE8000, 0, 0, 32'h00008000, 0, 0);
    send_word(ACT_ADD, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 0, 0, 0);
    s_tvalid <= 1'b0;
    // hold off until the unit is empty
    wait_drained();
    // random bursts with gaps, receiver pattern changes per phase
    while (sent < 440) begin
      if (sent > 120) stall_mode = (sent / 90) % 4;
      repeat ($urandom_range(1, 20)) send_random();
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    stall_mode = 1;
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered %0d words over all eight actions, with sender gaps and", sent);
    $display("receiver stalls; %0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
